### src/assert_macros.svh
// assertion helper macros shared by the vibration alarm rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check on the rising clock edge, disabled while reset is held
`define VAC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same check, clocked but also evaluated during reset
`define VAC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/vac_pkg.sv
// shared types, constants and helpers for the vibration alarm classifier
// no dependencies
`default_nettype none

package vac_pkg;

    // default sizing
    localparam int CAL_SAMPLES_DEF = 50;
    localparam int SAMPLE_BITS_DEF = 10;

    // fixed field widths
    localparam int FIELD_W   = 10;
    localparam int SUM_W     = 16;
    localparam int PCT_W     = 7;
    localparam int MARGIN_W  = 8;
    localparam int DROP_W    = 10;
    localparam int NIB_W     = 4;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 5;

    // register reset values
    localparam logic [MARGIN_W-1:0] NOISE_MARGIN_RST = 8'd5;
    localparam logic [MARGIN_W-1:0] QUAKE_MARGIN_RST = 8'd12;
    localparam logic [DROP_W-1:0]   DROP_LIMIT_RST   = 10'd122;
    localparam logic [NIB_W-1:0]    DEV_CAP_RST      = 4'd10;
    localparam logic [NIB_W-1:0]    PCT_STEP_RST     = 4'd10;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_NOISE_MARGIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUAKE_MARGIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DROP_LIMIT   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEV_CAP      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PCT_STEP     = 3'd4;

    // condition codes
    localparam logic [1:0] COND_NORMAL = 2'd0;
    localparam logic [1:0] COND_QUAKE  = 2'd1;
    localparam logic [1:0] COND_NOISE  = 2'd2;
    localparam logic [1:0] COND_ERROR  = 2'd3;

    // led colours, bit0 red, bit1 green, bit2 blue
    localparam logic [2:0] LED_GREEN    = 3'h2;
    localparam logic [2:0] LED_RED      = 3'h1;
    localparam logic [2:0] LED_BLUE     = 3'h4;
    localparam logic [2:0] LED_RED_BLUE = 3'h5;

    // percent limits
    localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;
    localparam logic [PCT_W-1:0] BAND_LOW_TOP = 7'd50;
    localparam logic [PCT_W-1:0] BAND_MID_TOP = 7'd80;

    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    typedef struct packed {
        logic [MARGIN_W-1:0] noise_margin;
        logic [MARGIN_W-1:0] quake_margin;
        logic [DROP_W-1:0]   drop_limit;
        logic [NIB_W-1:0]    deviation_cap;
        logic [NIB_W-1:0]    percent_step;
    } t_cfg;

    // classifier outcome plus next flag state
    typedef struct packed {
        logic [1:0]       condition;
        logic [PCT_W-1:0] level_percent;
        logic [PCT_W-1:0] held_percent;
        logic             new_quake;
        logic [2:0]       led_colour;
        logic [1:0]       beep_band;
        logic             held_valid;
        logic             quake_seen;
    } t_class_res;

    function automatic logic [2:0] led_of(input logic [1:0] cond);
        logic [2:0] led;
        case (cond)
            COND_NORMAL: led = LED_GREEN;
            COND_QUAKE:  led = LED_RED;
            COND_NOISE:  led = LED_BLUE;
            default:     led = LED_RED_BLUE;
        endcase
        return led;
    endfunction

    function automatic logic [1:0] band_of(input logic [PCT_W-1:0] pct);
        logic [1:0] band;
        if (pct <= BAND_LOW_TOP) begin
            band = BAND_LOW;
        end else if (pct <= BAND_MID_TOP) begin
            band = BAND_MID;
        end else begin
            band = BAND_HIGH;
        end
        return band;
    endfunction

endpackage

`default_nettype wire

### src/vibration_alarm_classifier_top.sv
// vibration alarm classifier top level: input register, calibration, result register
// depends on vac_pkg, vac_classify and assert_macros.svh
//
// Usage
//   Slave stream s_t*: one accelerometer triple per request, tdata holds
//   x_sample [9:0], y_sample [19:10], z_sample [29:20].
//   Master stream m_t*: one classified result per request after calibration;
//   tuser holds condition, tdata holds level, held percent, quake flag, led, band.
//   APB port: five registers at byte addresses 0,4,8,12,16; write while idle.
//   Calibration: the first CAL_SAMPLES triples are summed, the next one turns
//   the sums into baselines (a reciprocal multiply per axis); none of these
//   give a result. Every later triple gives exactly one result.
//   An accepted triple goes from the input register to the result register,
//   which raises m_tvalid. Throughput: one triple per cycle unless m_tready
//   stalls the output, set by the single classification stage between them.
//   Reset (synchronous, active low) clears calibration, flags and registers
//   to their defaults. When m_tready is low the result register holds and
//   the input register fills, after which s_tready drops; calibration triples
//   still drain while the output is stalled.
`default_nettype none

module vibration_alarm_classifier_top #(
    parameter int CAL_SAMPLES = vac_pkg::CAL_SAMPLES_DEF,
    parameter int SAMPLE_BITS = vac_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // slave stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [31:0]                 s_tdata,   // x_sample, y_sample, z_sample
    // master stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [23:0]                      m_tdata,   // level_percent, held_percent,
                                                        // new_quake, led_colour, beep_band
    output logic [1:0]                       m_tuser,   // condition
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [vac_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import vac_pkg::*;
    `include "assert_macros.svh"

    localparam int SW       = SAMPLE_BITS;
    localparam int InW      = (SW < FIELD_W) ? SW : FIELD_W;
    localparam int CntW     = $clog2(CAL_SAMPLES + 2);
    localparam int CalShift = SUM_W + $clog2(CAL_SAMPLES);
    localparam int ProdW    =
        ((2*SUM_W+1) > (CalShift+SW)) ? (2*SUM_W+1) : (CalShift+SW);
    localparam logic [SUM_W:0] CalRecip =
        (SUM_W+1)'(((64'd1 << CalShift) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam logic [CntW-1:0] CntSum = CntW'(CAL_SAMPLES);
    localparam logic [CntW-1:0] CntRun = CntW'(CAL_SAMPLES + 1);

    // configuration registers
    t_cfg                 r_cfg;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;

    // input register
    logic                 r_in_valid;
    logic [SW-1:0]        r_smp [3];

    // calibration state
    logic [CntW-1:0]      r_cal_cnt;
    logic [SUM_W-1:0]     r_sum  [3];
    logic [SW-1:0]        r_base [3];
    logic [SW-1:0]        w_quot [3];

    // running flags
    logic [PCT_W-1:0]     r_percent;
    logic [PCT_W-1:0]     r_held;
    logic                 r_held_valid;
    logic                 r_quake_seen;

    // result register
    logic                 r_out_valid;
    t_class_res           r_out;

    logic                 w_cal_sum;
    logic                 w_cal_div;
    logic                 w_running;
    logic                 w_advance;
    logic                 w_emit;
    t_class_res           w_res;

    // apb access
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.noise_margin  <= NOISE_MARGIN_RST;
            r_cfg.quake_margin  <= QUAKE_MARGIN_RST;
            r_cfg.drop_limit    <= DROP_LIMIT_RST;
            r_cfg.deviation_cap <= DEV_CAP_RST;
            r_cfg.percent_step  <= PCT_STEP_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_NOISE_MARGIN: r_cfg.noise_margin  <= pwdata[MARGIN_W-1:0];
                REG_QUAKE_MARGIN: r_cfg.quake_margin  <= pwdata[MARGIN_W-1:0];
                REG_DROP_LIMIT:   r_cfg.drop_limit    <= pwdata[DROP_W-1:0];
                REG_DEV_CAP:      r_cfg.deviation_cap <= pwdata[NIB_W-1:0];
                REG_PCT_STEP:     r_cfg.percent_step  <= pwdata[NIB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (w_reg_idx)
            REG_NOISE_MARGIN: prdata = 32'(r_cfg.noise_margin);
            REG_QUAKE_MARGIN: prdata = 32'(r_cfg.quake_margin);
            REG_DROP_LIMIT:   prdata = 32'(r_cfg.drop_limit);
            REG_DEV_CAP:      prdata = 32'(r_cfg.deviation_cap);
            REG_PCT_STEP:     prdata = 32'(r_cfg.percent_step);
            default:          prdata = '0;
        endcase
    end

    // stage control
    assign w_cal_sum = (r_cal_cnt < CntSum);
    assign w_cal_div = (r_cal_cnt == CntSum);
    assign w_running = (r_cal_cnt == CntRun);
    assign w_advance = r_in_valid && (!w_running || !r_out_valid || m_tready);
    assign w_emit    = w_advance && w_running;
    assign s_tready  = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_smp[0] <= SW'(s_tdata[InW-1:0]);
            r_smp[1] <= SW'(s_tdata[FIELD_W+InW-1:FIELD_W]);
            r_smp[2] <= SW'(s_tdata[2*FIELD_W+InW-1:2*FIELD_W]);
        end
    end

    // calibration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_cnt <= '0;
        end else if (w_advance && !w_running) begin
            r_cal_cnt <= r_cal_cnt + CntW'(1);
        end
    end

    // per-axis sums and baselines, quotient by reciprocal multiply
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic [ProdW-1:0] w_prod;

        assign w_prod    = ProdW'(r_sum[a]) * ProdW'(CalRecip);
        assign w_quot[a] = w_prod[CalShift +: SW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[a]  <= '0;
                r_base[a] <= '0;
            end else if (w_advance && w_cal_sum) begin
                r_sum[a] <= r_sum[a] + SUM_W'(r_smp[a]);
            end else if (w_advance && w_cal_div) begin
                r_base[a] <= w_quot[a];
            end
        end
    end

    vac_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .i_x          (r_smp[0]),
        .i_y          (r_smp[1]),
        .i_z          (r_smp[2]),
        .i_base_x     (r_base[0]),
        .i_base_y     (r_base[1]),
        .i_base_z     (r_base[2]),
        .i_cfg        (r_cfg),
        .i_percent    (r_percent),
        .i_held       (r_held),
        .i_held_valid (r_held_valid),
        .i_quake_seen (r_quake_seen),
        .o_res        (w_res)
    );

    // running flags follow each classified triple
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_percent    <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_quake_seen <= 1'b0;
        end else if (w_emit) begin
            r_percent    <= w_res.level_percent;
            r_held       <= w_res.held_percent;
            r_held_valid <= w_res.held_valid;
            r_quake_seen <= w_res.quake_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.condition;
    assign m_tdata  = {4'b0, r_out.beep_band, r_out.led_colour, r_out.new_quake,
                       r_out.held_percent, r_out.level_percent};

    // checks
    `VAC_ASSERT(a_no_result_in_cal, i_clk, i_rst_n,
        $rose(r_out_valid) |-> w_running, "result produced before calibration ended")
    `VAC_ASSERT(a_quake_flag_cond, i_clk, i_rst_n,
        (r_out_valid && r_out.new_quake) |-> (r_out.condition == COND_QUAKE),
        "new quake flag on a non-quake result")
    `VAC_ASSERT(a_error_zero_level, i_clk, i_rst_n,
        (r_out_valid && r_out.condition == COND_ERROR) |-> (r_out.level_percent == '0),
        "sensor error result with non-zero level")
    `VAC_ASSERT(a_normal_clears, i_clk, i_rst_n,
        (w_emit && w_res.condition == COND_NORMAL) |=> (!r_held_valid && !r_quake_seen),
        "normal result left held or quake flags set")

endmodule

`default_nettype wire

### src/vac_classify.sv
// combinational classification of one triple against the stored baselines
// depends on vac_pkg
`default_nettype none

module vac_classify #(
    parameter int SAMPLE_BITS = vac_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic [SAMPLE_BITS-1:0]         i_x,
    input  wire logic [SAMPLE_BITS-1:0]         i_y,
    input  wire logic [SAMPLE_BITS-1:0]         i_z,
    input  wire logic [SAMPLE_BITS-1:0]         i_base_x,
    input  wire logic [SAMPLE_BITS-1:0]         i_base_y,
    input  wire logic [SAMPLE_BITS-1:0]         i_base_z,
    input  wire vac_pkg::t_cfg                  i_cfg,
    input  wire logic [vac_pkg::PCT_W-1:0]      i_percent,
    input  wire logic [vac_pkg::PCT_W-1:0]      i_held,
    input  wire logic                           i_held_valid,
    input  wire logic                           i_quake_seen,
    output vac_pkg::t_class_res                 o_res
);
    import vac_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int ZW = ((SW > DROP_W) ? SW : DROP_W) + 1;

    logic [SW-1:0]    w_dx;
    logic [SW-1:0]    w_dy;
    logic [SW-1:0]    w_nm;
    logic [SW-1:0]    w_qm;
    logic [SW-1:0]    w_cap;
    logic             w_noise_x;
    logic             w_noise_y;
    logic             w_quake;
    logic             w_error;
    logic [SW-1:0]    w_pct_dev;
    logic [NIB_W-1:0] w_capped;
    logic [7:0]       w_prod;
    logic [PCT_W-1:0] w_pct_new;

    // absolute deviations from baseline
    assign w_dx = (i_x >= i_base_x) ? (i_x - i_base_x) : (i_base_x - i_x);
    assign w_dy = (i_y >= i_base_y) ? (i_y - i_base_y) : (i_base_y - i_y);

    // thresholds widened to the sample width
    assign w_nm  = SW'(i_cfg.noise_margin);
    assign w_qm  = SW'(i_cfg.quake_margin);
    assign w_cap = SW'(i_cfg.deviation_cap);

    assign w_noise_x = (w_dx >= w_nm) && (w_dx < w_qm);
    assign w_noise_y = (w_dy >= w_nm) && (w_dy < w_qm);
    assign w_quake   = (w_dx >= w_qm) || (w_dy >= w_qm);
    assign w_error   = (ZW'(i_z) + ZW'(i_cfg.drop_limit)) <= ZW'(i_base_z);

    // percent from the chosen deviation, capped then saturated
    assign w_pct_dev = (!w_noise_x && w_noise_y) ? w_dy : w_dx;
    assign w_capped  = (w_pct_dev > w_cap) ? i_cfg.deviation_cap : w_pct_dev[NIB_W-1:0];
    assign w_prod    = 8'(i_cfg.percent_step) * 8'(w_capped);
    assign w_pct_new = (w_prod > 8'(PCT_MAX)) ? PCT_MAX : w_prod[PCT_W-1:0];

    // priority: error, noise, quake, normal
    always_comb begin
        o_res               = '0;
        o_res.held_percent  = i_held;
        o_res.held_valid    = i_held_valid;
        o_res.quake_seen    = i_quake_seen;
        o_res.level_percent = i_percent;
        if (w_error) begin
            o_res.condition     = COND_ERROR;
            o_res.level_percent = '0;
            o_res.held_valid    = 1'b0;
            o_res.quake_seen    = 1'b0;
        end else if (w_noise_x || w_noise_y) begin
            o_res.condition     = COND_NOISE;
            o_res.level_percent = w_pct_new;
            if (!i_held_valid) begin
                o_res.held_percent = w_pct_new;
                o_res.held_valid   = 1'b1;
            end
        end else if (w_quake) begin
            o_res.condition  = COND_QUAKE;
            o_res.new_quake  = !i_quake_seen;
            o_res.quake_seen = 1'b1;
        end else begin
            o_res.condition     = COND_NORMAL;
            o_res.level_percent = w_pct_new;
            o_res.held_valid    = 1'b0;
            o_res.quake_seen    = 1'b0;
        end
        o_res.led_colour = led_of(o_res.condition);
        o_res.beep_band  = band_of(o_res.level_percent);
    end

endmodule

`default_nettype wire
